FILE: hdl/iol_pkg.sv
`default_nettype none

package iol_pkg;

	// Command codes carried on the command field.
	typedef enum logic [2:0] {
		CMD_APPEND     = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Broadcast controls from the list controller to every cell.
	typedef struct packed {
		logic write;
		logic shift_back;
		logic shift_fwd;
	} cell_ctl_t;

	// Width of the external data and read ports.
	localparam int PORT_WIDTH = 32;
	// Width of the position and entry count ports.
	localparam int POS_PORT_WIDTH = 7;

endpackage

`default_nettype wire

FILE: hdl/iol_cell.sv
`default_nettype none

module iol_cell
	import iol_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int IW         = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [IW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [IW-1:0] SLOT = IW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	// The target slot takes the new word; slots behind it move toward the back
	// on insert, and slots at or behind it pull from their back neighbor on remove.
	always_ff @(posedge clk) begin
		if (ctl.write && (pos == SLOT)) begin
			data_q <= wr_data;
		end else if (ctl.shift_back && (SLOT > pos)) begin
			data_q <= left;
		end else if (ctl.shift_fwd && (SLOT >= pos)) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

FILE: hdl/indexed_ordered_list.sv
`default_nettype none

// Channel   Direction  Handshake             Beat contents
// in        sink       in_valid / in_ready   command, position, value
// out       source     out_valid / out_ready read_value, entry_count, status
//
// One command is accepted per cycle while the output can take a beat; its result
// appears in the output register on the next cycle. Every cell shifts, loads or
// holds in the same cycle, and the read path is a select over all cells.
// Reset clears the entry count and the output valid; the entries themselves are
// not cleared. A stalled output only blocks input while its beat is not taken.

module indexed_ordered_list
	import iol_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                command,
	input  logic [POS_PORT_WIDTH-1:0] position,
	input  logic signed [PORT_WIDTH-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [PORT_WIDTH-1:0] read_value,
	output logic [POS_PORT_WIDTH-1:0] entry_count,
	output logic [1:0]                status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > POS_PORT_WIDTH) ? CW : POS_PORT_WIDTH;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic                  out_valid_q;
	logic [PORT_WIDTH-1:0] rd_q;
	logic [POS_PORT_WIDTH-1:0] cnt_q;
	status_t               st_q;
	status_t               st_d;
	logic                  rd_ok;
	logic                  acc;
	logic                  full;
	logic                  empty;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         count_w;
	logic [PW-1:0]         count_d_w;
	logic [IW-1:0]         rd_idx;
	logic [IW-1:0]         cell_pos;
	cell_ctl_t             ctl_d;
	cell_ctl_t             cell_ctl;
	logic [DATA_WIDTH-1:0] wr_word;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [PORT_WIDTH-1:0] rd_ext;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign acc       = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign pos_w     = PW'(position);
	assign count_w   = PW'(count_q);
	assign count_d_w = PW'(count_d);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign rd_idx    = pos_w[IW-1:0];
	assign rd_word   = cell_data[rd_idx];

	// Conversion between the 32-bit ports and the stored word width.
	generate
		if (DATA_WIDTH >= PORT_WIDTH) begin : g_wide
			assign rd_ext  = rd_word[PORT_WIDTH-1:0];
			assign wr_word = {{(DATA_WIDTH-PORT_WIDTH){value[PORT_WIDTH-1]}}, value};
		end else begin : g_narrow
			assign rd_ext  = {{(PORT_WIDTH-DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
			assign wr_word = value[DATA_WIDTH-1:0];
		end
	endgenerate

	// Command decode, bound checks and the next count.
	always_comb begin
		st_d     = ST_OK;
		count_d  = count_q;
		ctl_d    = '0;
		cell_pos = rd_idx;
		rd_ok    = 1'b0;
		case (command)
			CMD_APPEND: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctl_d.write = 1'b1;
					cell_pos    = count_w[IW-1:0];
					count_d     = count_q + CW'(1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					st_d = ST_FULL;
				end else if (pos_w > count_w) begin
					st_d = ST_RANGE;
				end else begin
					ctl_d.write      = 1'b1;
					ctl_d.shift_back = 1'b1;
					count_d          = count_q + CW'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					ctl_d.shift_fwd = 1'b1;
					cell_pos        = '0;
					count_d         = count_q - CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else if (pos_w >= count_w) begin
					st_d = ST_RANGE;
				end else begin
					ctl_d.shift_fwd = 1'b1;
					count_d         = count_q - CW'(1);
				end
			end
			CMD_READ: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else if (pos_w >= count_w) begin
					st_d = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Cells only move on an accepted beat.
	always_comb begin
		cell_ctl = acc ? ctl_d : '0;
	end

	// Row of cells; each sees its front and back neighbor.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_w;
			logic [DATA_WIDTH-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = wr_word;
			end else begin : g_mid_l
				assign left_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_w = cell_data[gi];
			end else begin : g_mid_r
				assign right_w = cell_data[gi+1];
			end
			iol_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.IW        (IW),
				.INDEX     (gi)
			) u_cell (
				.clk    (clk),
				.ctl    (cell_ctl),
				.pos    (cell_pos),
				.wr_data(wr_word),
				.left   (left_w),
				.right  (right_w),
				.data   (cell_data[gi])
			);
		end
	endgenerate

	// Entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q  <= rd_ok ? rd_ext : '0;
			cnt_q <= count_d_w[POS_PORT_WIDTH-1:0];
			st_q  <= st_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = rd_q;
	assign entry_count = cnt_q;
	assign status      = st_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (st_d != ST_OK)) |=> (count_q == $past(count_q)))
		else $error("failed command changed the count");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (command == CMD_APPEND) && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the list");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (entry_count == count_w[POS_PORT_WIDTH-1:0]))
		else $error("reported count differs from held count");

	a_read_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (st_q != ST_OK)) |-> (rd_q == '0))
		else $error("failed command returned read data");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench
	import iol_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 64;
	localparam int POS_MAX = 2**POS_PORT_WIDTH - 1;
	localparam int CMD_UNKNOWN_LO = int'(CMD_READ) + 1;
	localparam int CMD_UNKNOWN_HI = 2**3 - 1;
	localparam int RANDOM_ITEMS = 930;
	localparam int MAX_REPORTS = 10;
	localparam int LONG_HOLD = 300;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	// Random phase flavors: grow the list, shrink it, or mix everything.
	localparam int PH_FILL = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIXED = 2;

	typedef struct {
		logic signed [PORT_WIDTH-1:0] read_value;
		logic [POS_PORT_WIDTH-1:0] entry_count;
		status_t status;
	} list_result_t;

	// Shadow copy of the list that predicts every result beat and checks it.
	class list_shadow;
		logic [PORT_WIDTH-1:0] entries [LIST_DEPTH];
		int list_len;
		list_result_t pending_results[$];
		int failures;
		int reports;
		int cmd_seen [8];
		int status_seen [4];
		int longest;

		// Remove the entry at p and pull later entries one place forward.
		function void close_gap(int p);
			int i;
			for (i = p; i + 1 < list_len; i++)
				entries[i] = entries[i + 1];
			list_len--;
		endfunction

		// Apply one accepted command beat and queue the result it must produce.
		function void apply_command(logic [2:0] cmd, logic [POS_PORT_WIDTH-1:0] pos,
				logic [PORT_WIDTH-1:0] val);
			list_result_t r;
			int p;
			int i;
			r.read_value = '0;
			r.status = ST_OK;
			p = int'(pos);
			case (cmd)
				CMD_APPEND: begin
					if (list_len >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						entries[list_len] = val;
						list_len++;
					end
				end
				CMD_INSERT: begin
					if (list_len >= LIST_DEPTH) begin
						r.status = ST_FULL;
					end else if (p > list_len) begin
						r.status = ST_RANGE;
					end else begin
						for (i = list_len; i > p; i--)
							entries[i] = entries[i - 1];
						entries[p] = val;
						list_len++;
					end
				end
				CMD_POP_FRONT: begin
					if (list_len == 0)
						r.status = ST_EMPTY;
					else
						close_gap(0);
				end
				CMD_REMOVE: begin
					if (list_len == 0)
						r.status = ST_EMPTY;
					else if (p >= list_len)
						r.status = ST_RANGE;
					else
						close_gap(p);
				end
				CMD_READ: begin
					if (list_len == 0)
						r.status = ST_EMPTY;
					else if (p >= list_len)
						r.status = ST_RANGE;
					else
						r.read_value = entries[p];
				end
				default: begin
				end
			endcase
			r.entry_count = POS_PORT_WIDTH'(list_len);
			pending_results.push_back(r);
			cmd_seen[cmd]++;
			status_seen[r.status]++;
			if (list_len > longest)
				longest = list_len;
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check_result(logic signed [PORT_WIDTH-1:0] rd,
				logic [POS_PORT_WIDTH-1:0] cnt, logic [1:0] st);
			list_result_t e;
			if (pending_results.size() == 0) begin
				failures++;
				if (reports < MAX_REPORTS)
					$display("%0t: result beat with nothing expected %s",
						$realtime, $sformatf("(value %0d count %0d status %0d)",
						rd, cnt, st));
				reports++;
			end else begin
				e = pending_results.pop_front();
				if (rd !== e.read_value || cnt !== e.entry_count || st !== e.status) begin
					failures++;
					if (reports < MAX_REPORTS)
						$display("%0t: mismatch, expected %s, got %s", $realtime,
							$sformatf("value %0d count %0d status %s",
							e.read_value, e.entry_count, e.status.name()),
							$sformatf("value %0d count %0d status %0d",
							rd, cnt, st));
					reports++;
				end
			end
		endfunction

		// Anything still queued at the end never came out of the block.
		function void finish_check();
			if (pending_results.size() != 0) begin
				failures += pending_results.size();
				$display("%0d expected result beats never arrived", pending_results.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [POS_PORT_WIDTH-1:0] position = '0;
	logic signed [PORT_WIDTH-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [PORT_WIDTH-1:0] read_value;
	logic [POS_PORT_WIDTH-1:0] entry_count;
	logic [1:0] status;

	list_shadow shadow = new();
	int burst_left = 0;
	bit hold_request = 1'b0;

	indexed_ordered_list u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.entry_count(entry_count),
		.status(status)
	);

	always #6ns clk = ~clk;

	// Offer one command beat and hold it until the block takes it.
	task automatic send_beat(input logic [2:0] cmd, input int pos,
			input logic [PORT_WIDTH-1:0] val);
		in_valid <= 1'b1;
		command <= cmd;
		position <= POS_PORT_WIDTH'(pos);
		value <= val;
		do @(posedge clk); while (!in_ready);
		shadow.apply_command(cmd, POS_PORT_WIDTH'(pos), val);
	endtask

	// Send in bursts; between bursts the valid line may drop for a random gap.
	task automatic paced_send(input logic [2:0] cmd, input int pos,
			input logic [PORT_WIDTH-1:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
		end
		send_beat(cmd, pos, val);
		burst_left--;
	endtask

	// Stop offering until every expected result has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_results.size() != 0);
	endtask

	// Build one random command, weighted by the phase flavor.
	task automatic random_item(input int kind);
		logic [2:0] cmd;
		int pos;
		logic [PORT_WIDTH-1:0] val;
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r >= 97) begin
			cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		end else if (kind == PH_FILL) begin
			if (r < 45) cmd = CMD_APPEND;
			else if (r < 80) cmd = CMD_INSERT;
			else if (r < 90) cmd = CMD_READ;
			else if (r < 93) cmd = CMD_POP_FRONT;
			else cmd = CMD_REMOVE;
		end else if (kind == PH_DRAIN) begin
			if (r < 35) cmd = CMD_POP_FRONT;
			else if (r < 70) cmd = CMD_REMOVE;
			else if (r < 85) cmd = CMD_READ;
			else if (r < 91) cmd = CMD_APPEND;
			else cmd = CMD_INSERT;
		end else begin
			if (r < 20) cmd = CMD_APPEND;
			else if (r < 40) cmd = CMD_INSERT;
			else if (r < 55) cmd = CMD_POP_FRONT;
			else if (r < 75) cmd = CMD_REMOVE;
			else cmd = CMD_READ;
		end

		// Mostly legal positions, with some anywhere in the field's range.
		len = shadow.list_len;
		if ($urandom_range(0, 99) < 15)
			pos = $urandom_range(0, POS_MAX);
		else if (cmd == CMD_INSERT)
			pos = $urandom_range(0, len);
		else if (len > 0)
			pos = $urandom_range(0, len - 1);
		else
			pos = 0;

		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'h0000_0000;
				default: val = 32'hffff_ffff;
			endcase
		end else begin
			val = $urandom;
		end
		paced_send(cmd, pos, val);
	endtask

	// Every accepted result beat is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_result(read_value, entry_count, status);
	end

	// Result side: stalls follow a pattern of their own, plus one long hold-off.
	initial begin
		int mode;
		int span;
		int period;
		int k;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			period = $urandom_range(2, 5);
			for (k = 0; k < span; k++) begin
				if (hold_request) begin
					hold_request = 1'b0;
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= (k % period == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Stimulus: reset, directed corner cases, then random phases.
	initial begin
		int i;
		int c;
		int phase;
		int phase_len;
		int issued;
		int guard;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Errors on an empty list, then a small list with extreme words.
		send_beat(CMD_POP_FRONT, 0, 32'h0);
		send_beat(CMD_REMOVE, 0, 32'h0);
		send_beat(CMD_READ, 0, 32'h0);
		send_beat(CMD_INSERT, 1, 32'h1234_5678);
		send_beat(CMD_INSERT, 0, 32'h8000_0000);
		send_beat(CMD_APPEND, 0, 32'h7fff_ffff);
		send_beat(CMD_APPEND, POS_MAX, 32'hffff_ffff);
		send_beat(CMD_INSERT, 3, 32'h0);
		send_beat(CMD_INSERT, 1, 32'h5a5a_5a5a);
		send_beat(CMD_INSERT, 6, 32'ha5a5_a5a5);
		for (i = 0; i < 5; i++)
			send_beat(CMD_READ, i, 32'h0);
		send_beat(CMD_READ, 5, 32'h0);
		send_beat(CMD_READ, POS_MAX, 32'h0);
		send_beat(CMD_REMOVE, POS_MAX, 32'h0);
		send_beat(CMD_REMOVE, 5, 32'h0);
		send_beat(CMD_REMOVE, 2, 32'h0);
		send_beat(CMD_POP_FRONT, 0, 32'h0);
		for (c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++)
			send_beat(3'(c), POS_MAX, $urandom);
		send_beat(CMD_READ, 0, 32'h0);

		// Random phases that grow the list, shrink it, or mix all commands.
		issued = 0;
		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			phase_len = $urandom_range(60, 140);
			if (phase == 2) begin
				hold_request = 1'b1;
				burst_left = 48;
			end
			if (phase == 4 || phase == 8)
				wait_for_drain();
			for (i = 0; i < phase_len && issued < RANDOM_ITEMS; i++) begin
				random_item(phase % 3);
				issued++;
			end
			phase++;
		end
		in_valid <= 1'b0;

		guard = 0;
		while (shadow.pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		shadow.finish_check();

		$display("Commands: append %0d, insert %0d, pop front %0d, remove %0d, %s",
			shadow.cmd_seen[CMD_APPEND], shadow.cmd_seen[CMD_INSERT],
			shadow.cmd_seen[CMD_POP_FRONT], shadow.cmd_seen[CMD_REMOVE],
			$sformatf("read %0d, unknown %0d", shadow.cmd_seen[CMD_READ],
			shadow.cmd_seen[5] + shadow.cmd_seen[6] + shadow.cmd_seen[7]));
		$display("Outcomes: ok %0d, full %0d, empty %0d, out of range %0d; longest list %0d",
			shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
			shadow.status_seen[ST_EMPTY], shadow.status_seen[ST_RANGE], shadow.longest);
		if (shadow.failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2400us;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
